FILE: sv/mfdl_pkg.sv
// ----------------------------------------------------------------------------
// Modulated fractional delay line package
// Shared constants, register indexes, sequencer states and helper functions.
// ----------------------------------------------------------------------------
package mfdl_pkg;

  // Default geometry of the delay store.
  localparam int BUFFER_DEPTH_DEF = 32768;
  localparam int CHANNELS_DEF     = 2;

  // Fixed sample format and sine resolution.
  localparam int SAMPLE_W   = 16;
  localparam int SINE_DEPTH = 256;
  localparam int SINE_Q     = SINE_DEPTH / 4;
  localparam int SINE_IW    = $clog2(SINE_DEPTH);
  localparam int SINE_KW    = $clog2(SINE_Q) + 1;
  localparam int SINE_VW    = 15;

  // Width of the bit-serial multiplier accumulator and its multiplier digit count.
  localparam int MUL_W   = 40;
  localparam int MUL_BW  = 16;
  localparam int MUL_CW  = $clog2(MUL_BW);

  // Configuration register widths.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 24;

  // Configuration register indexes.
  typedef enum logic [CFG_IW-1:0] {
    REG_DELAY_TARGET   = 3'd0,
    REG_FEEDBACK_GAIN  = 3'd1,
    REG_WET_MIX        = 3'd2,
    REG_LFO_DEPTH      = 3'd3,
    REG_LFO_PHASE_STEP = 3'd4,
    REG_MIN_DELAY      = 3'd5,
    REG_SMOOTH_SHIFT   = 3'd6
  } cfg_reg_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LFO,
    ST_POS,
    ST_RDA,
    ST_RDB,
    ST_ISET,
    ST_IMUL,
    ST_FSET,
    ST_FMUL,
    ST_WR,
    ST_MIX1,
    ST_MSET,
    ST_MIX2,
    ST_OUT
  } state_t;

  // Quarter-wave sine table, one 15-bit entry per point, point 0 in the lowest bits.
  function automatic logic [(SINE_Q+1)*SINE_VW-1:0] sine_rom();
    logic [(SINE_Q+1)*SINE_VW-1:0] rom;
    longint x, x2, inner, mid, s, r;
    rom = '0;
    for (int k = 0; k <= SINE_Q; k++) begin
      x     = (longint'(k) * 65536) / SINE_Q;
      x2    = (x * x) >> 16;
      inner = 42047 - ((x2 * 4640) >> 16);
      mid   = 102944 - ((x2 * inner) >> 16);
      s     = (x * mid) >> 16;
      r     = (s + 1) >> 1;
      if (r > 32767) r = 32767;
      rom[k*SINE_VW +: SINE_VW] = SINE_VW'(r);
    end
    return rom;
  endfunction

  // Saturate an accumulator value to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(input logic signed [MUL_W-1:0] v);
    logic signed [MUL_W-1:0] hi, lo;
    hi = MUL_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    lo = -hi - MUL_W'(1);
    if (v > hi) return SAMPLE_W'(hi);
    if (v < lo) return SAMPLE_W'(lo);
    return SAMPLE_W'(v);
  endfunction

endpackage

FILE: sv/modulated_fractional_delay_line_unit.sv
// ----------------------------------------------------------------------------
// Modulated fractional delay line unit
// Per-channel ring buffers with a sine-modulated, ramped fractional delay,
// linear interpolation, feedback and dry/wet mix.
// ----------------------------------------------------------------------------
// After reset the block zeroes every entry of its delay store, one entry per
// cycle; no item is taken during that pass but configuration writes are.
// Every arithmetic product goes through a single shift-and-add multiplier
// that consumes one multiplier bit per cycle, and the store has one read and
// one write port, so the sequencer handles one item at a time: an item on
// channel 0 needs five products and an item on another channel four, with
// control states between them. A new item may be accepted while the previous
// result still waits in the output register.
module modulated_fractional_delay_line_unit #(
  parameter int BUFFER_DEPTH = mfdl_pkg::BUFFER_DEPTH_DEF,
  parameter int CHANNELS     = mfdl_pkg::CHANNELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] sample_in
  input  logic                        s_axis_tuser,  // [0] channel
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata,  // [15:0] sample_out
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [mfdl_pkg::CFG_IW-1:0] cfg_index,
  input  logic [mfdl_pkg::CFG_DW-1:0] cfg_data
);

  localparam int MEM_DEPTH = CHANNELS * BUFFER_DEPTH;
  localparam int AW        = $clog2(MEM_DEPTH);
  localparam int WPW       = $clog2(BUFFER_DEPTH);
  localparam int CHW       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SPAN      = BUFFER_DEPTH * 256;
  localparam int PW        = $clog2(SPAN) + 2;
  localparam int DW        = 27;
  localparam int SW        = mfdl_pkg::SAMPLE_W;
  localparam int MW        = mfdl_pkg::MUL_W;
  localparam logic [(mfdl_pkg::SINE_Q+1)*mfdl_pkg::SINE_VW-1:0] SINE_ROM =
    mfdl_pkg::sine_rom();

  // Configuration registers.
  logic [23:0]        delay_target;
  logic signed [15:0] feedback_gain;
  logic [15:0]        wet_mix;
  logic [19:0]        lfo_depth;
  logic [23:0]        lfo_phase_step;
  logic [23:0]        min_delay;
  logic [3:0]         smooth_shift;

  // Modulation and ramp state.
  logic [23:0]        lfo_phase;
  logic signed [20:0] lfo_offset;
  logic [23:0]        current_delay;
  logic signed [24:0] ramp_step;
  logic [15:0]        ramp_left;

  // Sequencer and item registers.
  mfdl_pkg::state_t   state, state_next;
  logic signed [SW-1:0] x_reg;
  logic               chf;
  logic               sine_neg;
  logic [WPW-1:0]     wp [CHANNELS];
  logic [AW-1:0]      clr_addr;
  logic [AW-1:0]      addr_a, addr_b;
  logic [7:0]         frac;
  logic signed [SW-1:0] samp_a;
  logic signed [SW-1:0] delayed;

  // Bit-serial multiplier.
  logic signed [MW-1:0]          mul_a;
  logic [mfdl_pkg::MUL_BW-1:0]   mul_b;
  logic [mfdl_pkg::MUL_CW-1:0]   mul_cnt;
  logic signed [MW-1:0]          acc;
  logic                          mul_run;
  logic                          mul_done;

  // Delay store.
  logic signed [SW-1:0] mem [MEM_DEPTH];
  logic signed [SW-1:0] rdata;
  logic [AW-1:0]        rd_addr;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic signed [SW-1:0] mem_wdata;

  logic in_acc;
  logic cfg_acc;
  logic out_load;

  logic [CHW-1:0] ch;
  logic [AW-1:0]  ch_base;
  logic [WPW-1:0] wp_cur;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign mul_run  = (state == mfdl_pkg::ST_LFO) || (state == mfdl_pkg::ST_IMUL) ||
                    (state == mfdl_pkg::ST_FMUL) || (state == mfdl_pkg::ST_MIX1) ||
                    (state == mfdl_pkg::ST_MIX2);
  assign mul_done = (mul_cnt == {mfdl_pkg::MUL_CW{1'b1}});
  assign out_load = (state == mfdl_pkg::ST_OUT) && (!m_axis_tvalid || m_axis_tready);

  // Channel selection and ring base address.
  assign ch      = (CHANNELS > 1) ? CHW'(chf) : '0;
  assign ch_base = AW'(ch) * AW'(BUFFER_DEPTH);
  assign wp_cur  = wp[ch];

  // Sine lookup from the current phase.
  logic [mfdl_pkg::SINE_IW-1:0] sine_idx;
  logic [mfdl_pkg::SINE_KW-1:0] sine_k;
  logic [mfdl_pkg::SINE_VW-1:0] sine_mag;
  always_comb begin
    sine_idx = lfo_phase[23 -: mfdl_pkg::SINE_IW];
    if (sine_idx[mfdl_pkg::SINE_IW-2]) begin
      sine_k = mfdl_pkg::SINE_KW'(mfdl_pkg::SINE_Q) -
               mfdl_pkg::SINE_KW'(sine_idx[mfdl_pkg::SINE_IW-3:0]);
    end else begin
      sine_k = mfdl_pkg::SINE_KW'(sine_idx[mfdl_pkg::SINE_IW-3:0]);
    end
    sine_mag = SINE_ROM[sine_k*mfdl_pkg::SINE_VW +: mfdl_pkg::SINE_VW];
  end

  // Delay, clamp and read position.
  logic signed [20:0]   off_now;
  logic signed [DW-1:0] d_raw, d_clamp;
  logic [PW-1:0]        pos_sum, pos;
  logic [WPW-1:0]       before_idx, after_idx;
  always_comb begin
    if (!chf) begin
      off_now = sine_neg ? -21'(acc[35:15]) : 21'(acc[35:15]);
    end else begin
      off_now = lfo_offset;
    end
    d_raw = DW'($signed({1'b0, current_delay})) + DW'(off_now);
    d_clamp = d_raw;
    if (d_clamp < DW'($signed({1'b0, min_delay}))) d_clamp = DW'($signed({1'b0, min_delay}));
    if (d_clamp > DW'(SPAN)) d_clamp = DW'(SPAN);
    pos_sum = PW'({wp_cur, 8'd0}) + PW'(SPAN) - PW'(d_clamp);
    pos = (pos_sum >= PW'(SPAN)) ? pos_sum - PW'(SPAN) : pos_sum;
    before_idx = WPW'(pos >> 8);
    after_idx  = (before_idx == WPW'(BUFFER_DEPTH - 1)) ? '0 : before_idx + WPW'(1);
  end

  // Values formed between multiplier passes.
  logic signed [SW-1:0] del_now;
  logic signed [SW-1:0] stored;
  logic [16:0]          gain_abs;
  logic [15:0]          wet_eff;
  always_comb begin
    del_now  = samp_a + SW'(acc >>> 8);
    stored   = mfdl_pkg::sat_sample(MW'(x_reg) + (acc >>> 15));
    gain_abs = feedback_gain[15] ? 17'(-$signed({feedback_gain[15], feedback_gain}))
                                 : 17'(feedback_gain);
    wet_eff  = (wet_mix > 16'd32768) ? 16'd32768 : wet_mix;
  end

  // Store port selection.
  always_comb begin
    rd_addr   = (state == mfdl_pkg::ST_RDA) ? addr_a : addr_b;
    mem_we    = (state == mfdl_pkg::ST_CLEAR) || (state == mfdl_pkg::ST_WR);
    mem_waddr = (state == mfdl_pkg::ST_CLEAR) ? clr_addr : ch_base + AW'(wp_cur);
    mem_wdata = (state == mfdl_pkg::ST_CLEAR) ? '0 : stored;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[rd_addr];
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) state <= mfdl_pkg::ST_CLEAR;
    else     state <= state_next;
  end

  // Next state and input handshake.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    case (state)
      mfdl_pkg::ST_CLEAR: if (clr_addr == AW'(MEM_DEPTH - 1)) state_next = mfdl_pkg::ST_IDLE;
      mfdl_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_next = s_axis_tuser ? mfdl_pkg::ST_POS : mfdl_pkg::ST_LFO;
      end
      mfdl_pkg::ST_LFO:  if (mul_done) state_next = mfdl_pkg::ST_POS;
      mfdl_pkg::ST_POS:  state_next = mfdl_pkg::ST_RDA;
      mfdl_pkg::ST_RDA:  state_next = mfdl_pkg::ST_RDB;
      mfdl_pkg::ST_RDB:  state_next = mfdl_pkg::ST_ISET;
      mfdl_pkg::ST_ISET: state_next = mfdl_pkg::ST_IMUL;
      mfdl_pkg::ST_IMUL: if (mul_done) state_next = mfdl_pkg::ST_FSET;
      mfdl_pkg::ST_FSET: state_next = mfdl_pkg::ST_FMUL;
      mfdl_pkg::ST_FMUL: if (mul_done) state_next = mfdl_pkg::ST_WR;
      mfdl_pkg::ST_WR:   state_next = mfdl_pkg::ST_MIX1;
      mfdl_pkg::ST_MIX1: if (mul_done) state_next = mfdl_pkg::ST_MSET;
      mfdl_pkg::ST_MSET: state_next = mfdl_pkg::ST_MIX2;
      mfdl_pkg::ST_MIX2: if (mul_done) state_next = mfdl_pkg::ST_OUT;
      mfdl_pkg::ST_OUT:  if (out_load) state_next = mfdl_pkg::ST_IDLE;
      default:           state_next = mfdl_pkg::ST_IDLE;
    endcase
  end

  // Configuration writes and ramp start.
  logic signed [24:0] ramp_diff;
  logic [24:0]        ramp_mag;
  always_comb begin
    ramp_diff = $signed({1'b0, cfg_data[23:0]}) - $signed({1'b0, current_delay});
    ramp_mag  = ramp_diff[24] ? 25'(-ramp_diff) : 25'(ramp_diff);
    ramp_mag  = ramp_mag >> smooth_shift;
  end

  // Control and modulation state.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_target   <= '0;
      feedback_gain  <= '0;
      wet_mix        <= '0;
      lfo_depth      <= '0;
      lfo_phase_step <= '0;
      min_delay      <= 24'd12288;
      smooth_shift   <= 4'd9;
      lfo_phase      <= '0;
      lfo_offset     <= '0;
      current_delay  <= '0;
      ramp_step      <= '0;
      ramp_left      <= '0;
      clr_addr       <= '0;
      m_axis_tvalid  <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) wp[i] <= '0;
    end else begin
      if (cfg_acc) begin
        case (cfg_index)
          mfdl_pkg::REG_DELAY_TARGET: begin
            if (cfg_data != delay_target) begin
              delay_target <= cfg_data;
              ramp_left    <= 16'(17'd1 << smooth_shift);
              ramp_step    <= ramp_diff[24] ? -$signed(ramp_mag) : $signed(ramp_mag);
            end
          end
          mfdl_pkg::REG_FEEDBACK_GAIN:  feedback_gain  <= $signed(cfg_data[15:0]);
          mfdl_pkg::REG_WET_MIX:        wet_mix        <= cfg_data[15:0];
          mfdl_pkg::REG_LFO_DEPTH:      lfo_depth      <= cfg_data[19:0];
          mfdl_pkg::REG_LFO_PHASE_STEP: lfo_phase_step <= cfg_data;
          mfdl_pkg::REG_MIN_DELAY:      min_delay      <= cfg_data;
          mfdl_pkg::REG_SMOOTH_SHIFT:   smooth_shift   <= cfg_data[3:0];
          default: ;
        endcase
      end
      if (state == mfdl_pkg::ST_CLEAR) clr_addr <= clr_addr + AW'(1);
      // Channel 0 advances the phase and the delay ramp on acceptance.
      if (in_acc && !s_axis_tuser) begin
        lfo_phase <= lfo_phase + lfo_phase_step;
        if (ramp_left != '0) begin
          ramp_left <= ramp_left - 16'd1;
          if (ramp_left != 16'd1) current_delay <= 24'($signed({1'b0, current_delay}) + ramp_step);
          else                    current_delay <= delay_target;
        end
      end
      if (state == mfdl_pkg::ST_POS) lfo_offset <= off_now;
      if (state == mfdl_pkg::ST_WR) begin
        wp[ch] <= (wp_cur == WPW'(BUFFER_DEPTH - 1)) ? '0 : wp_cur + WPW'(1);
      end
      if (out_load) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // Datapath and multiplier passes.
  always_ff @(posedge clk) begin
    if (mul_run) begin
      if (mul_b[0]) acc <= acc + mul_a;
      mul_a   <= mul_a <<< 1;
      mul_b   <= mul_b >> 1;
      mul_cnt <= mul_cnt + mfdl_pkg::MUL_CW'(1);
    end
    case (state)
      mfdl_pkg::ST_IDLE: begin
        x_reg    <= $signed(s_axis_tdata);
        chf      <= s_axis_tuser;
        sine_neg <= sine_idx[mfdl_pkg::SINE_IW-1] && (sine_mag != '0);
        acc      <= '0;
        mul_a    <= MW'(lfo_depth);
        mul_b    <= mfdl_pkg::MUL_BW'(sine_mag);
        mul_cnt  <= '0;
      end
      mfdl_pkg::ST_POS: begin
        addr_a <= ch_base + AW'(before_idx);
        addr_b <= ch_base + AW'(after_idx);
        frac   <= pos[7:0];
      end
      mfdl_pkg::ST_RDB: samp_a <= rdata;
      mfdl_pkg::ST_ISET: begin
        acc     <= '0;
        mul_a   <= MW'($signed({rdata[SW-1], rdata}) - $signed({samp_a[SW-1], samp_a}));
        mul_b   <= mfdl_pkg::MUL_BW'(frac);
        mul_cnt <= '0;
      end
      mfdl_pkg::ST_FSET: begin
        delayed <= del_now;
        acc     <= '0;
        mul_a   <= feedback_gain[15] ? -MW'(del_now) : MW'(del_now);
        mul_b   <= gain_abs[15:0];
        mul_cnt <= '0;
      end
      mfdl_pkg::ST_WR: begin
        acc     <= '0;
        mul_a   <= MW'(x_reg);
        mul_b   <= 16'd32768 - wet_eff;
        mul_cnt <= '0;
      end
      mfdl_pkg::ST_MSET: begin
        mul_a   <= MW'(delayed);
        mul_b   <= wet_eff;
        mul_cnt <= '0;
      end
      default: ;
    endcase
    if (out_load) m_axis_tdata <= mfdl_pkg::sat_sample(acc >>> 15);
  end

`ifndef SYNTH
  // No item is taken while the store is being cleared.
  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    (state == mfdl_pkg::ST_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during store clear");

  // An accepted item leaves the idle state.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != mfdl_pkg::ST_IDLE))
    else $error("sequencer did not start on accepted item");

  // The last ramp step lands exactly on the target.
  a_ramp_lands: assert property (@(posedge clk) disable iff (rst)
    (in_acc && !s_axis_tuser && (ramp_left == 16'd1) && !cfg_acc)
    |=> (current_delay == delay_target))
    else $error("ramp did not end on target");

  // A multiplier pass always runs for its full digit count.
  a_mul_count: assert property (@(posedge clk) disable iff (rst)
    (mul_run && !mul_done) |=> (state == $past(state)))
    else $error("multiplier pass cut short");
`endif

endmodule

FILE: tb/tb_modulated_fractional_delay_line_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modulated fractional delay line unit testbench
// Feeds audio items on both channels under a sequence of register settings,
// predicts every mixed output sample with an in-bench model of the delay
// line, LFO and ramp, and compares each output item with its prediction.
// ----------------------------------------------------------------------------
module tb_modulated_fractional_delay_line_unit;

  localparam int DEPTH = 32768;
  localparam longint SPAN = 64'd8388608;
  localparam logic [mfdl_pkg::CFG_IW-1:0] REG_UNUSED = 3'd7;

  typedef struct {
    logic [15:0] smp;
    logic        ch;
  } audio_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mfdl_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [mfdl_pkg::CFG_DW-1:0] cfg_data = '0;

  modulated_fractional_delay_line_unit u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Items waiting to be sent and mixed samples waiting to come out.
  audio_item_t pending_items[$];
  logic [15:0] expected_samples[$];
  int errors = 0;
  bit idling_on = 1'b1;
  bit in_fire = 1'b0;
  bit cfg_fire = 1'b0;
  int in_gap = 0;
  int out_gap = 0;

  // Shadow of the block's registers and state.
  longint tgt_delay, fb_gain, wet_gain, lfo_amp, phase_inc, min_dly, ramp_shift;
  int     line_mem[2][DEPTH];
  int     wr_ptr[2];
  longint lfo_phase, lfo_off, cur_delay, ramp_inc, ramp_cnt;

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // Quarter-wave sine point k of 64, polynomial approximation in Q1.15.
  function automatic longint quarter_wave(longint k);
    longint x, x2, p, q, s, r;
    x  = (k * 65536) / 64;
    x2 = (x * x) >> 16;
    p  = 42047 - ((x2 * 4640) >> 16);
    q  = 102944 - ((x2 * p) >> 16);
    s  = (x * q) >> 16;
    r  = (s + 1) >> 1;
    return (r > 32767) ? 32767 : r;
  endfunction

  function automatic longint lfo_sine(longint ph);
    longint i;
    i = ph >> 16;
    if (i < 64) return quarter_wave(i);
    if (i < 128) return quarter_wave(128 - i);
    if (i < 192) return -quarter_wave(i - 128);
    return -quarter_wave(256 - i);
  endfunction

  task automatic model_reset();
    foreach (line_mem[c, k]) line_mem[c][k] = 0;
    wr_ptr[0] = 0; wr_ptr[1] = 0;
    lfo_phase = 0; lfo_off = 0; cur_delay = 0; ramp_inc = 0; ramp_cnt = 0;
    tgt_delay = 0; fb_gain = 0; wet_gain = 0; lfo_amp = 0; phase_inc = 0;
    min_dly = 12288; ramp_shift = 9;
  endtask

  task automatic model_write_reg(logic [mfdl_pkg::CFG_IW-1:0] idx,
                                 logic [mfdl_pkg::CFG_DW-1:0] val);
    longint diff, mag;
    case (idx)
      mfdl_pkg::REG_DELAY_TARGET: begin
        if (longint'(val) != tgt_delay) begin
          tgt_delay = val;
          ramp_cnt = 64'd1 << ramp_shift;
          diff = tgt_delay - cur_delay;
          mag = ((diff < 0) ? -diff : diff) >> ramp_shift;
          ramp_inc = (diff < 0) ? -mag : mag;
        end
      end
      mfdl_pkg::REG_FEEDBACK_GAIN:  fb_gain = longint'($signed(val[15:0]));
      mfdl_pkg::REG_WET_MIX:        wet_gain = val[15:0];
      mfdl_pkg::REG_LFO_DEPTH:      lfo_amp = val[19:0];
      mfdl_pkg::REG_LFO_PHASE_STEP: phase_inc = val;
      mfdl_pkg::REG_MIN_DELAY:      min_dly = val;
      mfdl_pkg::REG_SMOOTH_SHIFT:   ramp_shift = val[3:0];
      default: ;
    endcase
  endtask

  // Advance the delay line by one item and return the mixed sample.
  function automatic logic [15:0] mixed_sample(logic [15:0] raw, logic chan);
    longint x, s, mag, d, pos, acc, dly, stored, mixed, wet;
    int c, wp, b, a, f;
    x = longint'($signed(raw));
    c = chan;
    wp = wr_ptr[c];
    if (chan == 1'b0) begin
      s = lfo_sine(lfo_phase);
      mag = (lfo_amp * ((s < 0) ? -s : s)) >> 15;
      lfo_off = (s < 0) ? -mag : mag;
      lfo_phase = (lfo_phase + phase_inc) & 64'hFFFFFF;
      if (ramp_cnt > 0) begin
        ramp_cnt--;
        if (ramp_cnt > 0) cur_delay = (cur_delay + ramp_inc) & 64'hFFFFFF;
        else cur_delay = tgt_delay;
      end
    end
    // Lower clamp first, then the buffer length wins.
    d = cur_delay + lfo_off;
    if (d < min_dly) d = min_dly;
    if (d > SPAN) d = SPAN;
    pos = (longint'(wp) * 256 + SPAN - d) % SPAN;
    b = int'(pos >> 8);
    f = int'(pos & 255);
    a = (b + 1) % DEPTH;
    acc = longint'(line_mem[c][b]) * (256 - f) + longint'(line_mem[c][a]) * f;
    dly = acc >>> 8;
    stored = sat16(x + ((dly * fb_gain) >>> 15));
    line_mem[c][wp] = int'(stored);
    wet = (wet_gain > 32768) ? 32768 : wet_gain;
    mixed = sat16(((32768 - wet) * x + wet * dly) >>> 15);
    wr_ptr[c] = (wp + 1) % DEPTH;
    return mixed[15:0];
  endfunction

  // Monitor: record handshakes, predict accepted items, check results.
  always @(posedge clk) begin
    logic [15:0] want;
    in_fire  <= s_axis_tvalid && s_axis_tready;
    cfg_fire <= cfg_valid && cfg_ready;
    if (!rst && s_axis_tvalid && s_axis_tready)
      expected_samples.push_back(mixed_sample(s_axis_tdata, s_axis_tuser));
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        errors++;
        $display("%0t: unexpected output item: expected none, actual %0d", $time,
                 $signed(m_axis_tdata));
      end else begin
        want = expected_samples.pop_front();
        if (want !== m_axis_tdata) begin
          errors++;
          $display("%0t: sample_out mismatch: expected %0d, actual %0d", $time,
                   $signed(want), $signed(m_axis_tdata));
        end
      end
    end
  end

  // Sender: one item per handshake, with random bursts of idle cycles.
  always @(negedge clk) begin
    audio_item_t it;
    if (!s_axis_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_items.size() > 0 && !rst) begin
        it = pending_items.pop_front();
        s_axis_tdata <= it.smp;
        s_axis_tuser <= it.ch;
        s_axis_tvalid <= 1'b1;
        if (idling_on && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 16);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: ready with random stall bursts.
  always @(negedge clk) begin
    if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (idling_on && $urandom_range(0, 5) == 0) out_gap <= $urandom_range(1, 16);
    end
  end

  task automatic write_reg(logic [mfdl_pkg::CFG_IW-1:0] idx,
                           logic [mfdl_pkg::CFG_DW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    forever begin
      @(negedge clk);
      if (cfg_fire) break;
    end
    model_write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_item(logic [15:0] smp, logic ch);
    audio_item_t it;
    it.smp = smp;
    it.ch  = ch;
    pending_items.push_back(it);
  endtask

  // Wait until every queued item has gone through and come back out.
  task automatic drain();
    while (pending_items.size() != 0 || s_axis_tvalid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic random_items(int n);
    logic [15:0] smp;
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: smp = 16'h7FFF;
        1: smp = 16'h8000;
        default: smp = 16'($urandom_range(0, 65535));
      endcase
      queue_item(smp, ($urandom_range(0, 3) != 0) ? 1'b0 : 1'b1);
    end
  endtask

  task automatic random_settings();
    write_reg(mfdl_pkg::REG_SMOOTH_SHIFT, mfdl_pkg::CFG_DW'($urandom_range(0, 15)));
    write_reg(mfdl_pkg::REG_DELAY_TARGET, mfdl_pkg::CFG_DW'($urandom_range(0, 120 * 256)));
    write_reg(mfdl_pkg::REG_FEEDBACK_GAIN, mfdl_pkg::CFG_DW'($urandom_range(0, 65535)));
    write_reg(mfdl_pkg::REG_WET_MIX,
              mfdl_pkg::CFG_DW'(($urandom_range(0, 7) == 0) ? $urandom_range(32769, 65535)
                                                            : $urandom_range(0, 32768)));
    write_reg(mfdl_pkg::REG_LFO_DEPTH, mfdl_pkg::CFG_DW'($urandom_range(0, 40 * 256)));
    write_reg(mfdl_pkg::REG_LFO_PHASE_STEP, mfdl_pkg::CFG_DW'($urandom_range(0, 24'hFFFFFF)));
    write_reg(mfdl_pkg::REG_MIN_DELAY, mfdl_pkg::CFG_DW'($urandom_range(0, 40 * 256)));
  endtask

  // Stimulus and end of run.
  initial begin
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: short delays, a fast ramp, full wet and strong feedback.
    write_reg(mfdl_pkg::REG_SMOOTH_SHIFT, 24'd0);
    write_reg(mfdl_pkg::REG_MIN_DELAY, 24'd0);
    write_reg(mfdl_pkg::REG_DELAY_TARGET, 24'd896);
    write_reg(mfdl_pkg::REG_FEEDBACK_GAIN, 24'h8000);
    write_reg(mfdl_pkg::REG_WET_MIX, 24'd32768);
    write_reg(mfdl_pkg::REG_LFO_DEPTH, 24'd0);
    write_reg(mfdl_pkg::REG_LFO_PHASE_STEP, 24'd0);
    write_reg(REG_UNUSED, 24'hFFFFFF);
    queue_item(16'h7FFF, 1'b0); queue_item(16'h8000, 1'b1);
    queue_item(16'h0000, 1'b0); queue_item(16'hFFFF, 1'b1);
    queue_item(16'h8000, 1'b0); queue_item(16'h7FFF, 1'b1);
    queue_item(16'h0001, 1'b0); queue_item(16'h5555, 1'b0);
    queue_item(16'hAAAA, 1'b0); queue_item(16'h7FFF, 1'b0);
    drain();
    // Extremes: maximum feedback, wet above range, delay clamped at the buffer.
    write_reg(mfdl_pkg::REG_FEEDBACK_GAIN, 24'h7FFF);
    write_reg(mfdl_pkg::REG_WET_MIX, 24'hFFFF);
    write_reg(mfdl_pkg::REG_LFO_DEPTH, 24'hFFFFF);
    write_reg(mfdl_pkg::REG_LFO_PHASE_STEP, 24'hFFFFFF);
    write_reg(mfdl_pkg::REG_SMOOTH_SHIFT, 24'd15);
    write_reg(mfdl_pkg::REG_DELAY_TARGET, 24'd8388608);
    write_reg(mfdl_pkg::REG_MIN_DELAY, 24'd8388608);
    queue_item(16'h7FFF, 1'b0); queue_item(16'h8000, 1'b0);
    queue_item(16'h1234, 1'b1); queue_item(16'h8000, 1'b1);
    queue_item(16'h7FFF, 1'b0);
    drain();
    // Lower clamp crossing the upper, with a mid-range LFO.
    write_reg(mfdl_pkg::REG_MIN_DELAY, 24'hFFFFFF);
    write_reg(mfdl_pkg::REG_LFO_PHASE_STEP, 24'h040000);
    queue_item(16'h4000, 1'b0); queue_item(16'hC000, 1'b1);
    queue_item(16'h0100, 1'b0); queue_item(16'hFF00, 1'b0);
    drain();

    // Random phases; the last one runs without idling.
    for (int ph = 0; ph < 8; ph++) begin
      random_settings();
      if (ph == 7) idling_on = 1'b0;
      if (ph == 3) begin
        random_items(25);
        drain();
        random_items(25);
      end else begin
        random_items(50);
      end
      drain();
    end

    if (errors == 0) $display("modulated_fractional_delay_line_unit test passed");
    else $display("modulated_fractional_delay_line_unit test failed");
    $finish;
  end

  // Run limit, well beyond the clearing pass plus the slowest item stream.
  initial begin
    #(8_000_000);
    $display("modulated_fractional_delay_line_unit test failed");
    $finish;
  end

endmodule
